// File: rtl/core/servo_bus_command_framer_top_defines.svh
// ----------------------------------------------------------------------------
// Servo bus command framer: assertion macros
// Shared concurrent assertion helpers for the framer RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_COMMAND_FRAMER_TOP_DEFINES_SVH
`define SERVO_BUS_COMMAND_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBCF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SBCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/sbcf_pkg.sv
// ----------------------------------------------------------------------------
// sbcf_pkg
// Beat types, command codes and frame constants of the servo bus framer.
// ----------------------------------------------------------------------------
package sbcf_pkg;

   // command codes
   localparam logic [2:0] CMD_POS_WRITE  = 3'd0;
   localparam logic [2:0] CMD_LOAD_SLOT  = 3'd1;
   localparam logic [2:0] CMD_SYNC_WRITE = 3'd2;
   localparam logic [2:0] CMD_TORQUE     = 3'd3;
   localparam logic [2:0] CMD_SET_ID     = 3'd4;
   localparam logic [2:0] CMD_READ_ANGLE = 3'd5;

   // frame bytes
   localparam logic [7:0] HDR_BYTE      = 8'hFF;
   localparam logic [7:0] BCAST_ID      = 8'hFE;
   localparam logic [7:0] LEN_POS       = 8'h07;
   localparam logic [7:0] LEN_SHORT     = 8'h04;
   localparam logic [7:0] INS_WRITE     = 8'h03;
   localparam logic [7:0] INS_READ      = 8'h02;
   localparam logic [7:0] INS_SYNC      = 8'h83;
   localparam logic [7:0] REG_POS       = 8'h2A;
   localparam logic [7:0] REG_TORQUE    = 8'h28;
   localparam logic [7:0] REG_ID        = 8'h05;
   localparam logic [7:0] REG_ANGLE     = 8'h38;
   localparam logic [7:0] READ_LEN      = 8'h02;
   localparam logic [7:0] SYNC_DATA_LEN = 8'h04;
   localparam logic [7:0] MAX_SERVO_ID  = 8'd250;

   // checksum index of the position and short frames
   localparam int POS_LAST_IDX   = 10;
   localparam int SHORT_LAST_IDX = 7;

   localparam int CSR_DATA_W = 12;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  servo_id;
      logic [11:0] position;
      logic [15:0] move_time;
      logic [2:0]  slot;
      logic        enable;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
   } rsp_type;

endpackage

// File: rtl/core/sbcf_ram.sv
// ----------------------------------------------------------------------------
// sbcf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbcf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/servo_bus_command_framer_top.sv
// ----------------------------------------------------------------------------
// servo_bus_command_framer_top
// Builds serial bus servo command frames, one byte per output beat.
// ----------------------------------------------------------------------------
// A command is taken only while the framer is idle. It passes through
// decode (offset add and clamp), then the byte sequencer pushes one frame
// byte per cycle into the output register as long as rsp_stall stays low:
// 11 bytes for a position write, 38 for a sync write and 8 for torque, set-id
// and angle read. A sync slot load and any dropped command emit nothing.
// The six sync positions live in a small RAM; slots never loaded since reset
// read as the center position. The next command may be taken while the
// last byte of a frame still waits in the output register.
`include "servo_bus_command_framer_top_defines.svh"

module servo_bus_command_framer_top
   import sbcf_pkg::*;
#(
   parameter int NUM_SERVOS      = 6,
   parameter int CENTER_POSITION = 2000
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  req_type                            req,
   // frame byte channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rsp_type                            rsp,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [$clog2(NUM_SERVOS+2)-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]              csr_data
);

   localparam int SLOT_W    = $clog2(NUM_SERVOS);
   localparam int CSR_IDX_W = $clog2(NUM_SERVOS + 2);
   localparam int SYNC_LAST = 7 + 5 * NUM_SERVOS;
   localparam int CNT_W     = $clog2(SYNC_LAST + 1);

   localparam logic [7:0]           SYNC_LEN    = 8'(5 * NUM_SERVOS + 4);
   localparam logic [11:0]          CENTER_VAL  = 12'(CENTER_POSITION);
   localparam logic [CSR_IDX_W-1:0] CSR_POS_MIN = CSR_IDX_W'(NUM_SERVOS);
   localparam logic [CSR_IDX_W-1:0] CSR_POS_MAX = CSR_IDX_W'(NUM_SERVOS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // configuration registers
   logic signed [10:0] offset_ff [NUM_SERVOS];
   logic [11:0]        pos_min_ff;
   logic [11:0]        pos_max_ff;

   // control state
   logic [1:0]            state_ff,    state_in;
   logic [CNT_W-1:0]      cnt_ff,      cnt_in;
   logic [CNT_W-1:0]      last_idx_ff, last_idx_in;
   logic [2:0]            phase_ff,    phase_in;
   logic [SLOT_W-1:0]     slot_ff,     slot_in;
   logic [7:0]            sum_ff,      sum_in;
   logic [NUM_SERVOS-1:0] valid_ff,    valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   req_type     item_ff,  item_in;
   logic [11:0] pos_ff,   pos_in;
   rsp_type     rsp_ff,   rsp_in;

   // decode path
   logic              pos_cmd;
   logic [SLOT_W-1:0] off_idx;
   logic              off_hit;
   logic signed [10:0] off_val;
   logic signed [13:0] pos_sum;
   logic              above_max;
   logic              below_min;
   logic [11:0]       clamp_val;
   logic [11:0]       load_val;
   logic              slot_ok;
   logic              id_ok;

   // sequencer path
   logic              is_last;
   logic              out_load;
   logic [7:0]        frame_byte;
   logic [11:0]       sync_pos;
   logic [11:0]       ram_rd;
   logic              ram_we;

   // register write port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            offset_ff[i] <= '0;
         end
         pos_min_ff <= '0;
         pos_max_ff <= '1;
      end else if (csr_valid) begin
         if (csr_index < CSR_POS_MIN) begin
            offset_ff[csr_index[SLOT_W-1:0]] <= $signed(csr_data[10:0]);
         end else if (csr_index == CSR_POS_MIN) begin
            pos_min_ff <= csr_data;
         end else if (csr_index == CSR_POS_MAX) begin
            pos_max_ff <= csr_data;
         end
      end
   end

   // offset lookup, add and clamp
   assign pos_cmd = (item_ff.command == CMD_POS_WRITE);
   assign off_idx = pos_cmd ? (item_ff.servo_id[SLOT_W-1:0] - SLOT_W'(1))
                            : item_ff.slot[SLOT_W-1:0];
   assign off_hit = pos_cmd ? (item_ff.servo_id >= 8'd1 &&
                               item_ff.servo_id <= 8'(NUM_SERVOS))
                            : (item_ff.slot < 3'(NUM_SERVOS));
   assign off_val   = off_hit ? offset_ff[off_idx] : 11'sd0;
   assign pos_sum   = $signed({2'b00, item_ff.position}) + 14'(off_val);
   assign above_max = pos_sum > $signed({2'b00, pos_max_ff});
   assign below_min = pos_sum < $signed({2'b00, pos_min_ff});
   assign clamp_val = above_max ? pos_max_ff :
                      below_min ? pos_min_ff : pos_sum[11:0];
   assign load_val  = (above_max || below_min) ? CENTER_VAL : pos_sum[11:0];
   assign slot_ok   = (item_ff.slot < 3'(NUM_SERVOS));
   assign id_ok     = (item_ff.servo_id >= 8'd1 && item_ff.servo_id <= MAX_SERVO_ID);

   assign ram_we = (state_ff == ST_EXEC) && (item_ff.command == CMD_LOAD_SLOT) && slot_ok;

   // sync position store, read continuously at the current slot
   sbcf_ram #(
      .WIDTH (12),
      .DEPTH (NUM_SERVOS)
   ) u_sync_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (item_ff.slot[SLOT_W-1:0]),
      .wr_data (load_val),
      .rd_addr (slot_ff),
      .rd_data (ram_rd)
   );

   // unloaded slots read as center
   assign sync_pos = valid_ff[slot_ff] ? ram_rd : CENTER_VAL;

   assign is_last  = (cnt_ff == last_idx_ff);
   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // frame byte at the current count
   always_comb begin
      frame_byte = HDR_BYTE;
      if (is_last) begin
         frame_byte = ~sum_ff;
      end else if (cnt_ff >= CNT_W'(2)) begin
         unique case (item_ff.command)
            CMD_POS_WRITE: begin
               unique case (cnt_ff[3:0])
                  4'd2:    frame_byte = item_ff.servo_id;
                  4'd3:    frame_byte = LEN_POS;
                  4'd4:    frame_byte = INS_WRITE;
                  4'd5:    frame_byte = REG_POS;
                  4'd6:    frame_byte = {4'b0000, pos_ff[11:8]};
                  4'd7:    frame_byte = pos_ff[7:0];
                  4'd8:    frame_byte = item_ff.move_time[15:8];
                  default: frame_byte = item_ff.move_time[7:0];
               endcase
            end
            CMD_SYNC_WRITE: begin
               if (cnt_ff < CNT_W'(7)) begin
                  unique case (cnt_ff[2:0])
                     3'd2:    frame_byte = BCAST_ID;
                     3'd3:    frame_byte = SYNC_LEN;
                     3'd4:    frame_byte = INS_SYNC;
                     3'd5:    frame_byte = REG_POS;
                     default: frame_byte = SYNC_DATA_LEN;
                  endcase
               end else begin
                  unique case (phase_ff)
                     3'd0:    frame_byte = 8'(slot_ff) + 8'd1;
                     3'd1:    frame_byte = {4'b0000, sync_pos[11:8]};
                     3'd2:    frame_byte = sync_pos[7:0];
                     3'd3:    frame_byte = item_ff.move_time[15:8];
                     default: frame_byte = item_ff.move_time[7:0];
                  endcase
               end
            end
            CMD_TORQUE: begin
               unique case (cnt_ff[2:0])
                  3'd2:    frame_byte = BCAST_ID;
                  3'd3:    frame_byte = LEN_SHORT;
                  3'd4:    frame_byte = INS_WRITE;
                  3'd5:    frame_byte = REG_TORQUE;
                  default: frame_byte = {7'd0, item_ff.enable};
               endcase
            end
            CMD_SET_ID: begin
               unique case (cnt_ff[2:0])
                  3'd2:    frame_byte = BCAST_ID;
                  3'd3:    frame_byte = LEN_SHORT;
                  3'd4:    frame_byte = INS_WRITE;
                  3'd5:    frame_byte = REG_ID;
                  default: frame_byte = item_ff.servo_id;
               endcase
            end
            CMD_READ_ANGLE: begin
               unique case (cnt_ff[2:0])
                  3'd2:    frame_byte = item_ff.servo_id;
                  3'd3:    frame_byte = LEN_SHORT;
                  3'd4:    frame_byte = INS_READ;
                  3'd5:    frame_byte = REG_ANGLE;
                  default: frame_byte = READ_LEN;
               endcase
            end
            default: frame_byte = HDR_BYTE;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_idx_in  = last_idx_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      valid_in     = valid_ff;
      item_in      = item_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // output register drains independently
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cnt_in   = '0;
            phase_in = '0;
            slot_in  = '0;
            sum_in   = '0;
            pos_in   = clamp_val;
            state_in = ST_IDLE;
            unique case (item_ff.command)
               CMD_POS_WRITE: begin
                  last_idx_in = CNT_W'(POS_LAST_IDX);
                  state_in    = ST_EMIT;
               end
               CMD_LOAD_SLOT: begin
                  if (slot_ok) begin
                     valid_in[item_ff.slot[SLOT_W-1:0]] = 1'b1;
                  end
               end
               CMD_SYNC_WRITE: begin
                  last_idx_in = CNT_W'(SYNC_LAST);
                  state_in    = ST_EMIT;
               end
               CMD_TORQUE, CMD_READ_ANGLE: begin
                  last_idx_in = CNT_W'(SHORT_LAST_IDX);
                  state_in    = ST_EMIT;
               end
               CMD_SET_ID: begin
                  if (id_ok) begin
                     last_idx_in = CNT_W'(SHORT_LAST_IDX);
                     state_in    = ST_EMIT;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_in.frame_byte = frame_byte;
               rsp_in.last       = is_last;
               rsp_valid_in      = 1'b1;
               cnt_in            = cnt_ff + CNT_W'(1);
               if (cnt_ff >= CNT_W'(2) && !is_last) begin
                  sum_in = sum_ff + frame_byte;
               end
               // per-servo group walk of the sync frame
               if (item_ff.command == CMD_SYNC_WRITE && cnt_ff >= CNT_W'(7)) begin
                  if (phase_ff == 3'd4) begin
                     phase_in = '0;
                     slot_in  = slot_ff + SLOT_W'(1);
                  end else begin
                     phase_in = phase_ff + 3'd1;
                  end
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_idx_ff  <= '0;
         phase_ff     <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_idx_ff  <= last_idx_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // checks
   `SBCF_ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && !req_stall, state_ff == ST_EXEC, "accepted command did not enter decode")
   `SBCF_ASSERT_NOW(a_cnt_bound, clock, reset, state_ff == ST_EMIT, cnt_ff <= last_idx_ff, "byte count ran past frame end")
   `SBCF_ASSERT_NOW(a_ram_we_exec, clock, reset, ram_we, state_ff == ST_EXEC, "sync store written outside decode")
   `SBCF_ASSERT_NOW(a_phase_bound, clock, reset, state_ff == ST_EMIT, phase_ff <= 3'd4, "sync group phase out of range")
   `SBCF_ASSERT_NEXT(a_last_beat, clock, reset, out_load && is_last, rsp_valid && rsp.last && state_ff == ST_IDLE, "frame end not flagged on last beat")

endmodule
